[design/arr_pkg.sv]
// Package: shared types and constants for the address range allocator.
`default_nettype none
package arr_pkg;

  localparam int ADDR_BITS   = 48;
  localparam int MAX_REGIONS = 64;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int FLAG_W      = 8;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RESERVE = 2'd1,
    OP_FREE    = 2'd2,
    OP_LOOKUP  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic {
    CFG_AREA_START = 1'b0,
    CFG_AREA_END   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE,
    S_WRITE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start_addr;
    logic [ADDR_BITS-1:0] end_addr;
    logic                 used;
    logic [FLAG_W-1:0]    flags;
  } entry_t;

  typedef struct packed {
    logic                 holds;
    logic                 better;
    logic [ADDR_BITS-1:0] size;
  } eval_t;

endpackage
`default_nettype wire

[design/arr_table.sv]
// Region table: one-write, one-read memory with a registered read port.
`default_nettype none
module arr_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          init_i,
  input  logic [arr_pkg::ADDR_BITS-1:0] area_start_i,
  input  logic [arr_pkg::ADDR_BITS-1:0] area_end_i,
  input  logic                          rd_en_i,
  input  logic [arr_pkg::IDX_W-1:0]     rd_idx_i,
  output arr_pkg::entry_t               rd_ent_o,
  input  logic                          wr_en_i,
  input  logic [arr_pkg::IDX_W-1:0]     wr_idx_i,
  input  arr_pkg::entry_t               wr_ent_i
);
  import arr_pkg::*;

  entry_t mem_q [MAX_REGIONS];
  entry_t rdata_q;
  logic   fresh_q;
  logic   rd_fresh_q;
  entry_t area_ent;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_ent_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_idx_i];
    end
  end

  // Entry zero reads as the whole area until it is first written after reset or init.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q    <= 1'b1;
      rd_fresh_q <= 1'b0;
    end else begin
      if (init_i) begin
        fresh_q <= 1'b1;
      end else if (wr_en_i && wr_idx_i == '0) begin
        fresh_q <= 1'b0;
      end
      if (rd_en_i) begin
        rd_fresh_q <= fresh_q && (rd_idx_i == '0);
      end
    end
  end

  always_comb begin
    area_ent            = '0;
    area_ent.start_addr = area_start_i;
    area_ent.end_addr   = area_end_i;
  end

  assign rd_ent_o = rd_fresh_q ? area_ent : rdata_q;

endmodule
`default_nettype wire

[design/arr_eval.sv]
// Entry evaluation unit: size, best-fit compare and address containment.
`default_nettype none
module arr_eval (
  input  arr_pkg::entry_t               ent_i,
  input  logic [arr_pkg::ADDR_BITS-1:0] req_addr_i,
  input  logic [arr_pkg::ADDR_BITS-1:0] req_size_i,
  input  logic                          best_vld_i,
  input  logic [arr_pkg::ADDR_BITS-1:0] best_sz_i,
  output arr_pkg::eval_t                eval_o
);
  import arr_pkg::*;

  logic [ADDR_BITS-1:0] sz;

  assign sz = ent_i.end_addr - ent_i.start_addr;

  always_comb begin
    eval_o.size   = sz;
    eval_o.better = !ent_i.used && (sz >= req_size_i) && (!best_vld_i || sz < best_sz_i);
    eval_o.holds  = (ent_i.start_addr <= req_addr_i) && (req_addr_i < ent_i.end_addr);
  end

endmodule
`default_nettype wire

[design/address_range_allocator.sv]
// Top level: best-fit address range allocator with coalescing.
//
// Input channel (in_valid_i / in_stall_o) carries one request: opcode, address,
// size and flags. A transfer takes place when in_valid_i is high and in_stall_o
// is low. Output channel (out_valid_o / out_stall_i) returns one status result
// per request. Config writes set area_start (index 0) or area_end (index 1) and
// reinit the table; the user must write only while idle; nothing checks this.
//
// One request at a time: the sequencer scans the table through a single
// read port, decides, shifts the table tail for a split or merge, writes up
// to three new pieces and hands the result to the output register. The next
// request can be taken in the cycle after the result is registered. The
// finished result waits in the output register while the next request is
// already taken; if the receiver stalls, the next result holds in the done
// state until the register frees up.
// Reset sets one free region covering [4096, 2^47), no stored result.
`default_nettype none
module address_range_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [arr_pkg::ADDR_BITS-1:0] req_addr_i,
  input  logic [arr_pkg::ADDR_BITS-1:0] req_size_i,
  input  logic [arr_pkg::FLAG_W-1:0]    req_flags_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [arr_pkg::ADDR_BITS-1:0] region_start_o,
  output logic [arr_pkg::ADDR_BITS-1:0] region_end_o,
  output logic                          region_used_o,
  output logic [arr_pkg::FLAG_W-1:0]    region_flags_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [arr_pkg::ADDR_BITS-1:0] cfg_wdata_i
);
  import arr_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

  state_e state_q, state_d;

  // Configuration and fill count.
  logic [ADDR_BITS-1:0] area_start_q, area_end_q;
  logic [ADDR_BITS-1:0] new_start, new_end;
  logic [CNT_W-1:0]     count_q;

  // Latched request.
  opcode_e              op_q;
  logic [ADDR_BITS-1:0] addr_q, size_q;
  logic [FLAG_W-1:0]    flags_q;
  logic [ADDR_BITS:0]   end_q;
  logic                 ovf;
  logic [ADDR_BITS-1:0] end48;

  // Scan.
  logic [CNT_W-1:0]     scan_q;
  logic                 rd_vld_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic                 best_vld_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [ADDR_BITS-1:0] best_sz_q;
  entry_t               best_ent_q;
  logic                 hit_q;
  logic [IDX_W-1:0]     hit_idx_q;
  entry_t               hit_ent_q;
  entry_t               prev_ent_q;
  logic                 prev_free_q;
  logic [ADDR_BITS-1:0] prev_start_q;
  logic                 next_free_q;
  logic [ADDR_BITS-1:0] next_end_q;

  // Splice.
  entry_t               pc_q [3];
  logic [1:0]           k_q;
  logic [IDX_W-1:0]     lo_q;
  logic                 mv_up_q;
  logic [1:0]           mv_mag_q;
  logic [IDX_W-1:0]     mv_ptr_q;
  logic [CNT_W-1:0]     mv_left_q;
  logic [1:0]           wr_ptr_q;

  // Result.
  entry_t               res_q;
  status_e              status_q;
  logic                 out_valid_q;
  status_e              out_status_q;
  entry_t               out_ent_q;

  // Table port.
  logic                 rd_en, wr_en;
  logic [IDX_W-1:0]     rd_addr, wr_addr;
  entry_t               rd_ent, wr_ent;
  eval_t                ev;

  logic                 in_acc, out_free;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign ovf      = end_q[ADDR_BITS];
  assign end48    = end_q[ADDR_BITS-1:0];

  arr_table u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .init_i       (cfg_we_i),
    .area_start_i (new_start),
    .area_end_i   (new_end),
    .rd_en_i      (rd_en),
    .rd_idx_i     (rd_addr),
    .rd_ent_o     (rd_ent),
    .wr_en_i      (wr_en),
    .wr_idx_i     (wr_addr),
    .wr_ent_i     (wr_ent)
  );

  arr_eval u_eval (
    .ent_i      (rd_ent),
    .req_addr_i (addr_q),
    .req_size_i (size_q),
    .best_vld_i (best_vld_q),
    .best_sz_i  (best_sz_q),
    .eval_o     (ev)
  );

  // Area values after a pending configuration write.
  always_comb begin
    new_start = area_start_q;
    new_end   = area_end_q;
    if (cfg_we_i && cfg_idx_i == CFG_AREA_START) begin
      new_start = cfg_wdata_i;
    end
    if (cfg_we_i && cfg_idx_i == CFG_AREA_END) begin
      new_end = cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Decision: build up to three replacement pieces from the scan results.
  // ---------------------------------------------------------------------------
  logic                 d_left, d_right, d_change;
  entry_t               d_lent, d_ment, d_rent;
  logic [IDX_W-1:0]     d_lo;
  logic [1:0]           d_nold, d_k;
  status_e              d_st;
  logic [CNT_W:0]       d_cnt;
  logic [CNT_W-1:0]     d_tail_lo;
  logic [ADDR_BITS-1:0] d_fs, d_fe, d_split;

  always_comb begin
    d_left   = 1'b0;
    d_right  = 1'b0;
    d_change = 1'b0;
    d_lent   = '0;
    d_ment   = '0;
    d_rent   = '0;
    d_lo     = hit_idx_q;
    d_nold   = 2'd1;
    d_st     = ST_REJECT;
    d_fs     = addr_q;
    d_fe     = end48;
    d_split  = best_ent_q.start_addr + size_q;
    unique case (op_q)
      OP_ALLOC: begin
        d_lo = best_idx_q;
        if (size_q != '0 && best_vld_q) begin
          d_st     = ST_OK;
          d_change = 1'b1;
          d_ment   = '{best_ent_q.start_addr, d_split, 1'b1, flags_q};
          if (best_sz_q > size_q) begin
            d_right = 1'b1;
            d_rent  = '{d_split, best_ent_q.end_addr, 1'b0, '0};
          end
        end
      end
      OP_RESERVE: begin
        if (size_q != '0 && !ovf && hit_q && !hit_ent_q.used &&
            !(end_q > {1'b0, hit_ent_q.end_addr})) begin
          d_st     = ST_OK;
          d_change = 1'b1;
          d_ment   = '{addr_q, end48, 1'b1, flags_q};
          if (hit_ent_q.start_addr < addr_q) begin
            d_left = 1'b1;
            d_lent = '{hit_ent_q.start_addr, addr_q, 1'b0, '0};
          end
          if (hit_ent_q.end_addr > end48) begin
            d_right = 1'b1;
            d_rent  = '{end48, hit_ent_q.end_addr, 1'b0, '0};
          end
        end
      end
      OP_FREE: begin
        if (size_q == '0) begin
          d_st = ST_OK;
        end else if (!ovf && hit_q && hit_ent_q.used &&
                     !(end_q > {1'b0, hit_ent_q.end_addr})) begin
          d_st     = ST_OK;
          d_change = 1'b1;
          if (hit_ent_q.start_addr < addr_q) begin
            d_left = 1'b1;
            d_lent = '{hit_ent_q.start_addr, addr_q, 1'b1, hit_ent_q.flags};
          end else if (prev_free_q) begin
            d_lo   = hit_idx_q - IDX_W'(1);
            d_nold = d_nold + 2'd1;
            d_fs   = prev_start_q;
          end
          if (hit_ent_q.end_addr > end48) begin
            d_right = 1'b1;
            d_rent  = '{end48, hit_ent_q.end_addr, 1'b1, hit_ent_q.flags};
          end else if (next_free_q) begin
            d_nold = d_nold + 2'd1;
            d_fe   = next_end_q;
          end
          d_ment = '{d_fs, d_fe, 1'b0, '0};
        end
      end
      OP_LOOKUP: begin
        if (hit_q) begin
          d_st   = ST_OK;
          d_ment = hit_ent_q;
        end
      end
      default: ;
    endcase
    d_k   = 2'd1 + {1'b0, d_left} + {1'b0, d_right};
    d_cnt = {1'b0, count_q} + {{(CNT_W-1){1'b0}}, d_k} - {{(CNT_W-1){1'b0}}, d_nold};
    if (d_change && d_cnt > {1'b0, MAX_CNT}) begin
      d_st     = ST_FULL;
      d_change = 1'b0;
    end
    d_tail_lo = {1'b0, d_lo} + {{(CNT_W-2){1'b0}}, d_nold};
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = S_SCAN;
      S_SCAN:   if (scan_q >= count_q && !rd_vld_q) state_d = S_DECIDE;
      S_DECIDE: state_d = d_change ? S_MOVE : S_DONE;
      S_MOVE:   if (mv_left_q == '0 && !rd_vld_q) state_d = S_WRITE;
      S_WRITE:  if (wr_ptr_q == k_q - 2'd1) state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Table port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mv_ptr_q;
    wr_en   = 1'b0;
    wr_addr = lo_q + {{(IDX_W-2){1'b0}}, wr_ptr_q};
    wr_ent  = pc_q[wr_ptr_q];
    unique case (state_q)
      S_SCAN: begin
        rd_en   = scan_q < count_q;
        rd_addr = scan_q[IDX_W-1:0];
      end
      S_MOVE: begin
        rd_en   = mv_left_q != '0;
        wr_en   = rd_vld_q;
        wr_ent  = rd_ent;
        wr_addr = mv_up_q ? rd_idx_q + {{(IDX_W-2){1'b0}}, mv_mag_q}
                          : rd_idx_q - {{(IDX_W-2){1'b0}}, mv_mag_q};
      end
      S_WRITE:  wr_en = 1'b1;
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      area_start_q <= ADDR_BITS'(4096);
      area_end_q   <= ADDR_BITS'(1) << (ADDR_BITS - 1);
      count_q      <= CNT_W'(1);
      rd_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (cfg_we_i) begin
        area_start_q <= new_start;
        area_end_q   <= new_end;
        count_q      <= (new_end > new_start) ? CNT_W'(1) : '0;
      end else if (state_q == S_DECIDE && d_change) begin
        count_q <= d_cnt[CNT_W-1:0];
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_addr;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_q        <= opcode_e'(opcode_i);
          addr_q      <= req_addr_i;
          size_q      <= req_size_i;
          flags_q     <= req_flags_i;
          end_q       <= {1'b0, req_addr_i} + {1'b0, req_size_i};
          scan_q      <= '0;
          best_vld_q  <= 1'b0;
          hit_q       <= 1'b0;
          prev_free_q <= 1'b0;
          next_free_q <= 1'b0;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          scan_q <= scan_q + CNT_W'(1);
        end
        if (rd_vld_q) begin
          prev_ent_q <= rd_ent;
          // Keep the smallest fitting free region; ties stay with the first.
          if (ev.better) begin
            best_vld_q <= 1'b1;
            best_idx_q <= rd_idx_q;
            best_sz_q  <= ev.size;
            best_ent_q <= rd_ent;
          end
          // Take the first region holding the address and its free neighbors.
          if (ev.holds && !hit_q) begin
            hit_q        <= 1'b1;
            hit_idx_q    <= rd_idx_q;
            hit_ent_q    <= rd_ent;
            prev_free_q  <= (rd_idx_q != '0) && !prev_ent_q.used;
            prev_start_q <= prev_ent_q.start_addr;
          end
          if (hit_q && rd_idx_q == hit_idx_q + IDX_W'(1)) begin
            next_free_q <= !rd_ent.used;
            next_end_q  <= rd_ent.end_addr;
          end
        end
      end
      S_DECIDE: begin
        status_q <= d_st;
        res_q    <= (d_st == ST_OK) ? d_ment : '0;
        pc_q[0]  <= d_left ? d_lent : d_ment;
        pc_q[1]  <= d_left ? d_ment : d_rent;
        pc_q[2]  <= d_rent;
        k_q      <= d_k;
        lo_q     <= d_lo;
        wr_ptr_q <= '0;
        mv_up_q  <= d_k > d_nold;
        mv_mag_q <= (d_k > d_nold) ? d_k - d_nold : d_nold - d_k;
        // Shift the tail up or down around the spliced range: top down when growing.
        mv_left_q <= (d_k != d_nold) ? count_q - d_tail_lo : '0;
        mv_ptr_q  <= (d_k > d_nold) ? IDX_W'(count_q - CNT_W'(1))
                                    : d_tail_lo[IDX_W-1:0];
      end
      S_MOVE: begin
        if (rd_en) begin
          mv_left_q <= mv_left_q - CNT_W'(1);
          mv_ptr_q  <= mv_up_q ? mv_ptr_q - IDX_W'(1) : mv_ptr_q + IDX_W'(1);
        end
      end
      S_WRITE: wr_ptr_q <= wr_ptr_q + 2'd1;
      S_DONE: begin
        if (out_free) begin
          out_status_q <= status_q;
          out_ent_q    <= res_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o     = state_q != S_IDLE;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign region_start_o = out_ent_q.start_addr;
  assign region_end_o   = out_ent_q.end_addr;
  assign region_used_o  = out_ent_q.used;
  assign region_flags_o = out_ent_q.flags;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("region count exceeds table depth");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
      region_start_o == '0 && region_end_o == '0 && !region_used_o && region_flags_o == '0)
    else $error("failed result carries region fields");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == S_MOVE || state_q == S_WRITE)
    else $error("table written outside splice");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("new request taken while busy");

endmodule
`default_nettype wire
